// File: design/frac_pkg.sv
package frac_pkg;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_CMD,
    PH_DATA,
    PH_SUM,
    PH_TAIL,
    PH_READ,
    PH_EMIT
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_TAIL = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  localparam logic CFG_MARKER  = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  localparam logic [7:0] MARKER_RESET  = 8'h2A;
  localparam logic [5:0] MAX_LEN_RESET = 6'd32;
  localparam int         MAX_RESULTS   = 32;

endpackage

// File: design/frame_receiver_additive_checksum_top.sv
// Noise, header, payload and checksum bytes: no result.
// Length, tail or checksum error, or a good empty frame: one result, valid in the cycle after the transfer.
// Good frame of N payload bytes: N results, each a payload RAM read, then emit.
// No byte is taken during readout or while a result waits in the output register.
// rst (synchronous): hunting for the marker, state and config registers to defaults; payload RAM is not cleared.
module frame_receiver_additive_checksum_top #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] frame_status,
  output logic [7:0] command_code,
  output logic [7:0] payload_value,
  output logic [4:0] payload_index,
  output logic [5:0] payload_count,
  output logic       last
);
  import frac_pkg::*;

  localparam int STORE_DEPTH = (PAYLOAD_DEPTH < MAX_RESULTS) ? PAYLOAD_DEPTH : MAX_RESULTS;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [5:0] LEN_CAP = 6'(STORE_DEPTH);

  logic [7:0] marker_byte;
  logic [5:0] max_payload;

  phase_t     phase, phase_next;
  logic [5:0] frame_length;
  logic [7:0] frame_command;
  logic [7:0] running_sum;
  logic [5:0] bytes_received;
  logic [7:0] sum_received;
  logic [4:0] rd_idx;

  logic [7:0] payload_store [STORE_DEPTH];
  logic [7:0] rd_data;

  logic       in_fire, out_free;
  logic [5:0] limit;
  logic       len_bad;
  logic       data_done;
  logic       rd_last;
  logic       tail_bad, sum_bad;

  logic       load_out;
  status_t    ld_status;
  logic [7:0] ld_cmd, ld_value;
  logic [4:0] ld_index;
  logic [5:0] ld_count;
  logic       ld_last;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (phase != PH_READ) && (phase != PH_EMIT) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign limit     = (max_payload > LEN_CAP) ? LEN_CAP : max_payload;
  assign len_bad   = rx_byte > {2'b00, limit};
  assign data_done = (bytes_received + 6'd1) >= frame_length;
  assign rd_last   = ({1'b0, rd_idx} + 6'd1) == frame_length;
  assign tail_bad  = rx_byte != marker_byte;
  assign sum_bad   = sum_received != running_sum;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT: if (in_fire && rx_byte == marker_byte) phase_next = PH_LEN;
      PH_LEN:  if (in_fire) phase_next = len_bad ? PH_HUNT : PH_CMD;
      PH_CMD:  if (in_fire) phase_next = (frame_length == 6'd0) ? PH_SUM : PH_DATA;
      PH_DATA: if (in_fire && data_done) phase_next = PH_SUM;
      PH_SUM:  if (in_fire) phase_next = PH_TAIL;
      PH_TAIL: begin
        if (in_fire) begin
          if (!tail_bad && !sum_bad && frame_length != 6'd0) phase_next = PH_READ;
          else phase_next = PH_HUNT;
        end
      end
      PH_READ: phase_next = PH_EMIT;
      PH_EMIT: if (out_free) phase_next = rd_last ? PH_HUNT : PH_READ;
      default: phase_next = PH_HUNT;
    endcase
  end

  always_comb begin
    load_out  = 1'b0;
    ld_status = ST_GOOD;
    ld_cmd    = 8'd0;
    ld_value  = 8'd0;
    ld_index  = 5'd0;
    ld_count  = 6'd0;
    ld_last   = 1'b1;
    unique case (phase)
      PH_LEN: begin
        if (in_fire && len_bad) begin
          load_out  = 1'b1;
          ld_status = ST_TOO_LONG;
        end
      end
      PH_TAIL: begin
        if (in_fire) begin
          if (tail_bad) begin
            load_out  = 1'b1;
            ld_status = ST_BAD_TAIL;
          end else if (sum_bad) begin
            load_out  = 1'b1;
            ld_status = ST_BAD_SUM;
          end else if (frame_length == 6'd0) begin
            load_out = 1'b1;
            ld_cmd   = frame_command;
          end
        end
      end
      PH_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_cmd   = frame_command;
          ld_value = rd_data;
          ld_index = rd_idx;
          ld_count = frame_length;
          ld_last  = rd_last;
        end
      end
      default: load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (phase == PH_DATA && in_fire && bytes_received < LEN_CAP) begin
      payload_store[bytes_received[AW-1:0]] <= rx_byte;
    end
    if (phase == PH_READ) begin
      rd_data <= payload_store[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_byte    <= MARKER_RESET;
      max_payload    <= MAX_LEN_RESET;
      phase          <= PH_HUNT;
      frame_length   <= 6'd0;
      frame_command  <= 8'd0;
      running_sum    <= 8'd0;
      bytes_received <= 6'd0;
      sum_received   <= 8'd0;
      rd_idx         <= 5'd0;
      out_valid      <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MARKER:  marker_byte <= cfg_data;
          CFG_MAX_LEN: max_payload <= cfg_data[5:0];
          default:     marker_byte <= marker_byte;
        endcase
      end
      if (in_fire) begin
        case (phase)
          PH_LEN: if (!len_bad) frame_length <= rx_byte[5:0];
          PH_CMD: begin
            frame_command  <= rx_byte;
            running_sum    <= 8'd0;
            bytes_received <= 6'd0;
          end
          PH_DATA: begin
            running_sum    <= running_sum + rx_byte;
            bytes_received <= bytes_received + 6'd1;
          end
          PH_SUM:  sum_received <= rx_byte;
          PH_TAIL: rd_idx <= 5'd0;
          default: rd_idx <= rd_idx;
        endcase
      end
      if (phase == PH_EMIT && out_free) rd_idx <= rd_idx + 5'd1;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      frame_status  <= ld_status;
      command_code  <= ld_cmd;
      payload_value <= ld_value;
      payload_index <= ld_index;
      payload_count <= ld_count;
      last          <= ld_last;
    end
  end

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    frame_length <= LEN_CAP)
    else $error("frame length above cap");

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_READ || phase == PH_EMIT) |-> ({1'b0, rd_idx} < frame_length))
    else $error("readout index past frame length");

  a_len_err: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_LEN && len_bad) |=>
      (out_valid && frame_status == ST_TOO_LONG && phase == PH_HUNT))
    else $error("oversize length not reported");

  a_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (phase == PH_READ || phase == PH_EMIT))
    else $error("non-final result outside readout");

  a_data_cnt: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_received < frame_length))
    else $error("payload count overrun");

endmodule

// File: tb/sv/frame_receiver_additive_checksum_top_test.sv
module frame_receiver_additive_checksum_top_test;
  import frac_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int STORE_DEPTH = 32;

  typedef enum {
    FR_GOOD,
    FR_BAD_TAIL,
    FR_BAD_SUM,
    FR_BAD_BOTH
  } frame_kind_t;

  typedef struct {
    status_t    status;
    logic [7:0] command;
    logic [7:0] value;
    logic [4:0] index;
    logic [5:0] count;
    logic       last;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_addr = CFG_MARKER;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] frame_status;
  logic [7:0] command_code;
  logic [7:0] payload_value;
  logic [4:0] payload_index;
  logic [5:0] payload_count;
  logic       last;

  logic [7:0]    rx_stream[$];
  frame_result_t pending_results[$];

  logic [7:0] marker_cfg = MARKER_RESET;
  logic [5:0] limit_cfg = MAX_LEN_RESET;

  phase_t     rx_phase;
  logic [5:0] rx_len;
  logic [7:0] rx_cmd;
  logic [7:0] rx_sum;
  logic [7:0] sum_seen;
  int         rx_count;
  logic [7:0] frame_bytes[STORE_DEPTH];

  bit steady = 1'b0;
  bit held_off = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int checked = 0;
  int bytes_sent = 0;
  int good_frames = 0;
  int rejected_frames = 0;
  int cycle_count = 0;

  frame_receiver_additive_checksum_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_status(frame_status),
    .command_code(command_code),
    .payload_value(payload_value),
    .payload_index(payload_index),
    .payload_count(payload_count),
    .last(last)
  );

  always #1 clk = ~clk;

  function automatic int frame_limit();
    return (limit_cfg > STORE_DEPTH) ? STORE_DEPTH : int'(limit_cfg);
  endfunction

  function automatic void add_result(status_t status, logic [7:0] command, logic [7:0] value,
                                     logic [4:0] index, logic [5:0] count, logic fin);
    frame_result_t r;
    r.status = status;
    r.command = command;
    r.value = value;
    r.index = index;
    r.count = count;
    r.last = fin;
    pending_results.push_back(r);
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    case (rx_phase)
      PH_LEN: begin
        if (int'(b) > frame_limit()) begin
          add_result(ST_TOO_LONG, 8'h00, 8'h00, 5'd0, 6'd0, 1'b1);
          rejected_frames++;
          rx_phase = PH_HUNT;
        end else begin
          rx_len = b[5:0];
          rx_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        rx_cmd = b;
        rx_sum = 8'h00;
        rx_count = 0;
        rx_phase = (rx_len == 0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        if (rx_count < STORE_DEPTH) frame_bytes[rx_count] = b;
        rx_sum = rx_sum + b;
        rx_count++;
        if (rx_count >= rx_len) rx_phase = PH_SUM;
      end
      PH_SUM: begin
        sum_seen = b;
        rx_phase = PH_TAIL;
      end
      PH_TAIL: begin
        rx_phase = PH_HUNT;
        if (b != marker_cfg) begin
          add_result(ST_BAD_TAIL, 8'h00, 8'h00, 5'd0, 6'd0, 1'b1);
          rejected_frames++;
        end else if (sum_seen != rx_sum) begin
          add_result(ST_BAD_SUM, 8'h00, 8'h00, 5'd0, 6'd0, 1'b1);
          rejected_frames++;
        end else if (rx_len == 0) begin
          add_result(ST_GOOD, rx_cmd, 8'h00, 5'd0, 6'd0, 1'b1);
          good_frames++;
        end else begin
          for (int i = 0; i < rx_len && i < STORE_DEPTH; i++)
            add_result(ST_GOOD, rx_cmd, frame_bytes[i], i[4:0], rx_len, (i + 1 == rx_len));
          good_frames++;
        end
      end
      default: rx_phase = (b == marker_cfg) ? PH_LEN : PH_HUNT;
    endcase
  endtask

  // sender, which also predicts results from the accepted bytes
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_phase = PH_HUNT;
      rx_len = 6'd0;
      rx_cmd = 8'h00;
      rx_sum = 8'h00;
      sum_seen = 8'h00;
      rx_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(rx_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (rx_stream.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
          in_valid <= 1'b1;
          rx_byte <= rx_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d cmd %0h value %0h",
                 frame_status, command_code, payload_value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (frame_status !== want.status) begin
            $error("frame_status: expected %0d, got %0d", want.status, frame_status);
            errors++;
          end
          if (command_code !== want.command) begin
            $error("command_code: expected %0h, got %0h", want.command, command_code);
            errors++;
          end
          if (payload_value !== want.value) begin
            $error("payload_value: expected %0h, got %0h", want.value, payload_value);
            errors++;
          end
          if (payload_index !== want.index) begin
            $error("payload_index: expected %0d, got %0d", want.index, payload_index);
            errors++;
          end
          if (payload_count !== want.count) begin
            $error("payload_count: expected %0d, got %0d", want.count, payload_count);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        // one long back-pressure window so the input side stalls
        if (!held_off && checked >= 8) begin
          held_off = 1'b1;
          hold_left = 150;
        end
        out_ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic set_reg(input logic addr, input logic [7:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_MARKER) marker_cfg = data;
    else limit_cfg = data[5:0];
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (rx_stream.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_frame(input int len, input logic [7:0] cmd, input frame_kind_t kind);
    logic [7:0] sum;
    logic [7:0] data;
    sum = 8'h00;
    rx_stream.push_back(marker_cfg);
    rx_stream.push_back(8'(len));
    rx_stream.push_back(cmd);
    for (int i = 0; i < len; i++) begin
      data = ($urandom_range(7) == 0) ? marker_cfg : 8'($urandom);
      sum = sum + data;
      rx_stream.push_back(data);
    end
    if (kind == FR_BAD_SUM || kind == FR_BAD_BOTH) sum = sum + 8'($urandom_range(1, 255));
    rx_stream.push_back(sum);
    if (kind == FR_BAD_TAIL || kind == FR_BAD_BOTH)
      rx_stream.push_back(marker_cfg ^ 8'($urandom_range(1, 255)));
    else
      rx_stream.push_back(marker_cfg);
  endtask

  task automatic queue_random(input int n);
    int base;
    int lim;
    int len;
    int pick;
    logic [7:0] cmd;
    base = rx_stream.size();
    lim = frame_limit();
    while (rx_stream.size() - base < n) begin
      pick = $urandom_range(99);
      len = ($urandom_range(7) == 0) ? lim : $urandom_range(0, (lim < 4) ? lim : 4);
      cmd = 8'($urandom);
      if (pick < 66) begin
        push_frame(len, cmd, FR_GOOD);
      end else if (pick < 72) begin
        push_frame(len, cmd, FR_BAD_TAIL);
      end else if (pick < 78) begin
        push_frame(len, cmd, FR_BAD_SUM);
      end else if (pick < 81) begin
        push_frame(len, cmd, FR_BAD_BOTH);
      end else if (pick < 88) begin
        rx_stream.push_back(marker_cfg);
        rx_stream.push_back(8'($urandom_range(lim + 1, 255)));
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 3)) rx_stream.push_back(8'($urandom));
      end else begin
        // frame cut short; the following bytes land in its fields
        rx_stream.push_back(marker_cfg);
        rx_stream.push_back(8'(len));
        rx_stream.push_back(cmd);
        repeat ($urandom_range(0, len)) rx_stream.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // noise, marker values as data, empty frame, tail and checksum errors, oversize
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(marker_cfg);
    rx_stream.push_back(8'd2);
    rx_stream.push_back(marker_cfg);
    rx_stream.push_back(marker_cfg);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(marker_cfg + 8'hFF);
    rx_stream.push_back(marker_cfg);
    push_frame(0, 8'hFF, FR_GOOD);
    push_frame(0, 8'h00, FR_BAD_BOTH);
    push_frame(0, 8'h5A, FR_BAD_SUM);
    rx_stream.push_back(marker_cfg);
    rx_stream.push_back(8'd33);
    wait_idle();

    queue_random(80);
    wait_idle();

    set_reg(CFG_MARKER, 8'h00);
    set_reg(CFG_MAX_LEN, 8'd0);
    queue_random(45);
    wait_idle();

    steady = 1'b1;
    set_reg(CFG_MARKER, 8'hFF);
    set_reg(CFG_MAX_LEN, 8'd1);
    queue_random(45);
    wait_idle();
    steady = 1'b0;

    set_reg(CFG_MARKER, 8'($urandom_range(1, 254)));
    set_reg(CFG_MAX_LEN, 8'd63);
    push_frame(32, 8'($urandom), FR_GOOD);
    queue_random(70);
    wait_idle();

    set_reg(CFG_MARKER, MARKER_RESET);
    set_reg(CFG_MAX_LEN, 8'd5);
    queue_random(45);
    wait_idle();

    repeat (20) @(posedge clk);
    $display("%0d bytes sent, %0d good and %0d rejected frames, %0d results checked",
             bytes_sent, good_frames, rejected_frames, checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/frac_pkg.sv
design/frame_receiver_additive_checksum_top.sv
tb/sv/frame_receiver_additive_checksum_top_test.sv
